// File: sv/dfs_pkg.sv
// Package: types and constants for the DFS discovery/finish time block.
`default_nettype none
package dfs_pkg;
	localparam int MAX_VERTICES_DEF = 64;

	typedef enum logic [1:0] {
		MODE_ADD   = 2'd0,
		MODE_RUN   = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_NOP   = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLR,
		ST_INIT,
		ST_ROOT,
		ST_READ,
		ST_SCAN,
		ST_EMIT_RD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [6:0] from_vertex;
		logic [6:0] to_vertex;
	} in_word_t;

	typedef struct packed {
		logic [6:0] vertex;
		logic [7:0] discover_time;
		logic [7:0] finish_time;
		logic       last;
	} out_word_t;
endpackage
`default_nettype wire

// File: sv/dfs_discovery_finish_times.sv
// Top level: DFS discovery and finish times over an adjacency bit matrix memory.
//
//  channel  | signals                     | word
//  ---------+-----------------------------+-----------
//  in       | in_valid / in_ready / in_word | mode, from_vertex, to_vertex
//  out      | out_valid / out_ready / out_word | vertex, times, last
//  cfg      | cfg_we / cfg_wdata          | vertex_count
//
// Edge add: one word per cycle (read-modify-write on the row memory), except that a word
// targeting the row still being written back is held off until that write-back is done.
// Clear: sweeps every row of the row memory to zero; reset runs the same sweep first.
// Run: walks the graph (one root check per vertex, a row read and a scan per discover or
// finish), then emits one result word per vertex, each held while out_ready is low.
// in_ready stays low from a clear or run word until it is done.
`default_nettype none
module dfs_discovery_finish_times #(
	parameter int MAX_VERTICES = dfs_pkg::MAX_VERTICES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire dfs_pkg::in_word_t in_word,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output dfs_pkg::out_word_t     out_word,
	input  wire logic              cfg_we,
	input  wire logic [6:0]        cfg_wdata
);
	import dfs_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CW = VW + 1;

	// memories
	logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
	logic [VW-1:0]           stk_mem [MAX_VERTICES];
	logic [7:0]              dsc_mem [MAX_VERTICES];
	logic [7:0]              fin_mem [MAX_VERTICES];

	state_t state_q, state_d;
	logic [6:0]              vcount_q;
	logic [CW-1:0]           n_q;
	logic [CW-1:0]           idx_q;          // clear sweep / root / emit index
	logic [CW-1:0]           sp_q;
	logic [7:0]              time_q;
	logic [MAX_VERTICES-1:0] white_q;
	logic [VW-1:0]           top_q;          // vertex on top of stack
	logic [MAX_VERTICES-1:0] row_rd_q;
	logic [7:0]              dsc_rd_q, fin_rd_q;
	logic                    pend_q;         // pending edge write
	logic [VW-1:0]           pend_row_q;
	logic [MAX_VERTICES-1:0] pend_bit_q;
	logic                    out_valid_q;
	out_word_t               out_q;

	// eff vertex count
	logic [CW-1:0] n_eff;
	always_comb begin
		if (vcount_q == 7'd0)
			n_eff = CW'(1);
		else if (vcount_q > 7'(MAX_VERTICES))
			n_eff = CW'(MAX_VERTICES);
		else
			n_eff = vcount_q[CW-1:0];
	end

	logic [MAX_VERTICES-1:0] range_mask;
	always_comb begin
		for (int j = 0; j < MAX_VERTICES; j++)
			range_mask[j] = (CW'(j) < n_q);
	end

	// lowest white neighbor of the row just read
	logic [MAX_VERTICES-1:0] cand;
	logic                    cand_any;
	logic [VW-1:0]           cand_idx;
	always_comb begin
		cand = row_rd_q & white_q & range_mask;
		cand_any = |cand;
		cand_idx = '0;
		for (int j = MAX_VERTICES - 1; j >= 0; j--)
			if (cand[j])
				cand_idx = VW'(j);
	end

	logic add_ok;
	logic [VW-1:0] from_i, to_i;
	assign add_ok = (in_word.from_vertex >= 7'd1) && (in_word.from_vertex <= 7'(MAX_VERTICES))
		&& (in_word.to_vertex >= 7'd1) && (in_word.to_vertex <= 7'(MAX_VERTICES));
	assign from_i = VW'(in_word.from_vertex - 7'd1);
	assign to_i   = VW'(in_word.to_vertex - 7'd1);

	logic accept;
	assign accept = in_valid && in_ready;

	// ready: idle, and no pending write to the row this word targets
	always_comb begin
		in_ready = (state_q == ST_IDLE) && !(pend_q && (in_word.mode == MODE_ADD)
			&& add_ok && pend_row_q == from_i);
	end

	logic idx_last;
	assign idx_last  = (idx_q == n_q - CW'(1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && in_word.mode == MODE_CLEAR)
					state_d = ST_CLR;
				else if (accept && in_word.mode == MODE_RUN)
					state_d = ST_INIT;
			end
			ST_CLR:
				if (idx_q == CW'(MAX_VERTICES - 1))
					state_d = ST_IDLE;
			ST_INIT: state_d = ST_ROOT;
			ST_ROOT: begin
				if (white_q[idx_q[VW-1:0]])
					state_d = ST_READ;
				else if (idx_last)
					state_d = ST_EMIT_RD;
			end
			ST_READ: state_d = ST_SCAN;
			ST_SCAN: begin
				if (cand_any)
					state_d = ST_READ;
				else if (sp_q == CW'(1))
					state_d = idx_last ? ST_EMIT_RD : ST_ROOT;
				else
					state_d = ST_READ;
			end
			ST_EMIT_RD: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_valid_q && out_ready)
					state_d = idx_last ? ST_IDLE : ST_EMIT_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			vcount_q    <= 7'd1;
			idx_q       <= '0;
			n_q         <= CW'(1);
			sp_q        <= '0;
			time_q      <= '0;
			white_q     <= '1;
			top_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				vcount_q <= cfg_wdata;
			pend_q <= accept && (in_word.mode == MODE_ADD) && add_ok;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && in_word.mode == MODE_CLEAR)
						idx_q <= '0;
				end
				ST_CLR: idx_q <= (idx_q == CW'(MAX_VERTICES - 1)) ? '0 : idx_q + CW'(1);
				ST_INIT: begin
					n_q     <= n_eff;
					idx_q   <= '0;
					sp_q    <= '0;
					time_q  <= '0;
					white_q <= '1;
				end
				ST_ROOT: begin
					if (white_q[idx_q[VW-1:0]]) begin
						white_q[idx_q[VW-1:0]] <= 1'b0;
						time_q <= time_q + 8'd1;
						top_q  <= idx_q[VW-1:0];
						sp_q   <= sp_q + CW'(1);
					end else if (idx_last) begin
						idx_q <= '0;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				ST_READ: ;
				ST_SCAN: begin
					time_q <= time_q + 8'd1;
					if (cand_any) begin
						white_q[cand_idx] <= 1'b0;
						top_q <= cand_idx;
						sp_q  <= sp_q + CW'(1);
					end else begin
						sp_q <= sp_q - CW'(1);
						if (sp_q == CW'(1))
							idx_q <= idx_last ? '0 : idx_q + CW'(1);
						else
							top_q <= stk_mem[sp_q[VW-1:0] - VW'(2)];
					end
				end
				ST_EMIT_RD: ;
				ST_EMIT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
					end else if (out_ready) begin
						out_valid_q <= 1'b0;
						idx_q <= idx_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// memory ports
	logic               adj_we;
	logic [VW-1:0]      adj_waddr;
	logic [MAX_VERTICES-1:0] adj_wdata;
	always_comb begin
		adj_we    = 1'b0;
		adj_waddr = pend_row_q;
		adj_wdata = row_rd_q | pend_bit_q;
		if (state_q == ST_CLR) begin
			adj_we    = 1'b1;
			adj_waddr = idx_q[VW-1:0];
			adj_wdata = '0;
		end else if (pend_q) begin
			adj_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adj_we)
			adj_mem[adj_waddr] <= adj_wdata;
		if (state_q == ST_READ)
			row_rd_q <= adj_mem[top_q];
		else
			row_rd_q <= adj_mem[from_i];
		pend_row_q <= from_i;
		pend_bit_q <= MAX_VERTICES'(1) << to_i;
		// discovery (root or child) and finish timestamps
		if (state_q == ST_ROOT && white_q[idx_q[VW-1:0]]) begin
			stk_mem[sp_q[VW-1:0]] <= idx_q[VW-1:0];
			dsc_mem[idx_q[VW-1:0]] <= time_q + 8'd1;
		end
		if (state_q == ST_SCAN) begin
			if (cand_any) begin
				stk_mem[sp_q[VW-1:0]] <= cand_idx;
				dsc_mem[cand_idx] <= time_q + 8'd1;
			end else begin
				fin_mem[top_q] <= time_q + 8'd1;
			end
		end
		dsc_rd_q <= dsc_mem[idx_q[VW-1:0]];
		fin_rd_q <= fin_mem[idx_q[VW-1:0]];
		if (state_q == ST_EMIT && !out_valid_q) begin
			out_q.vertex        <= 7'(idx_q) + 7'd1;
			out_q.discover_time <= dsc_rd_q;
			out_q.finish_time   <= fin_rd_q;
			out_q.last          <= idx_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// assertions
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= CW'(MAX_VERTICES)) else $error("stack overflow");
	a_busy_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready) else $error("ready while busy");
	a_out_only_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (state_q == ST_EMIT)) else $error("result outside emit");
	a_time_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (time_q < 8'(2 * MAX_VERTICES))) else $error("time overflow");
endmodule
`default_nettype wire

// File: test/dfs_discovery_finish_times_checker.sv
// Checker: watches the input and output channels, predicts DFS timestamps and compares.
module dfs_discovery_finish_times_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  dfs_pkg::in_word_t  in_word,
	input  logic               out_valid,
	input  logic               out_ready,
	input  dfs_pkg::out_word_t out_word,
	input  logic               cfg_we,
	input  logic [6:0]         cfg_wdata,
	output int                 fail_count,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import dfs_pkg::*;

	localparam int NV = MAX_VERTICES_DEF;

	logic [NV-1:0] adj_rows [NV];
	logic [6:0] vcount;
	out_word_t expected_times[$];

	assign pending = expected_times.size();

	// Walk the graph with an explicit stack and queue one word per vertex.
	task automatic predict_timestamps();
		logic [1:0] color [NV];
		logic [7:0] disc [NV];
		logic [7:0] fin [NV];
		int stack [NV];
		int depth, n, u, v;
		logic [7:0] clock_ticks;
		out_word_t w;
		n = (vcount < 1) ? 1 : ((vcount > NV) ? NV : vcount);
		for (int i = 0; i < NV; i++)
			color[i] = 2'd0;
		clock_ticks = '0;
		depth = 0;
		for (int root = 0; root < n; root++) begin
			if (color[root] == 2'd0) begin
				color[root] = 2'd1;
				clock_ticks++;
				disc[root] = clock_ticks;
				stack[depth++] = root;
				while (depth > 0) begin
					u = stack[depth-1];
					v = -1;
					for (int j = 0; j < n; j++)
						if (v < 0 && adj_rows[u][j] && color[j] == 2'd0)
							v = j;
					if (v >= 0) begin
						color[v] = 2'd1;
						clock_ticks++;
						disc[v] = clock_ticks;
						stack[depth++] = v;
					end else begin
						depth--;
						color[u] = 2'd2;
						clock_ticks++;
						fin[u] = clock_ticks;
					end
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			w.vertex = 7'(i + 1);
			w.discover_time = disc[i];
			w.finish_time = fin[i];
			w.last = (i + 1 == n);
			expected_times.push_back(w);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount = 7'd1;
			for (int i = 0; i < NV; i++)
				adj_rows[i] = '0;
			expected_times.delete();
			fail_count = 0;
		end else begin
			if (cfg_we)
				vcount = cfg_wdata;
			if (in_valid && in_ready) begin
				unique case (mode_t'(in_word.mode))
					MODE_ADD: begin
						if (in_word.from_vertex >= 1 && in_word.from_vertex <= NV &&
								in_word.to_vertex >= 1 && in_word.to_vertex <= NV)
							adj_rows[in_word.from_vertex-1][in_word.to_vertex-1] = 1'b1;
					end
					MODE_CLEAR: begin
						for (int i = 0; i < NV; i++)
							adj_rows[i] = '0;
					end
					MODE_RUN: predict_timestamps();
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_times.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected word: %p", out_word);
				end else begin
					out_word_t e;
					e = expected_times.pop_front();
					if (e !== out_word) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %p, got %p", e, out_word);
					end
				end
			end
		end
	end
endmodule

// File: test/dfs_discovery_finish_times_tb.sv
// Testbench top: stimulus, idling phases and verdict for the DFS timestamp block.
module dfs_discovery_finish_times_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dfs_pkg::*;

	localparam int LIMIT = 1000000;
	localparam int HOLD_CYCLES = 1000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_word;
	logic cfg_we = 1'b0;
	logic [6:0] cfg_wdata = '0;
	int fail_count, pending;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_off = 0;
	int cycle_count = 0;
	int vc = 1;

	always #1 clk = ~clk;

	dfs_discovery_finish_times DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
		.out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	dfs_discovery_finish_times_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
		.out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .pending(pending)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off when requested
	always @(negedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_off <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_off > 0) begin
			out_ready <= 1'b0;
			hold_off <= hold_off - 1;
		end else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// valid stays up between back-to-back words; idle gaps drop it
	task automatic send_word(input logic [1:0] m, input logic [6:0] f, input logic [6:0] t);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_word <= '{mode: m, from_vertex: f, to_vertex: t};
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_and_settle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic write_vertex_count(input logic [6:0] value);
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		vc = (value < 1) ? 1 : ((value > 64) ? 64 : value);
	endtask

	// mostly edges inside the active range, a few stray or odd ones
	task automatic random_word();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			send_word(MODE_ADD, 7'($urandom_range(1, vc)), 7'($urandom_range(1, vc)));
		else if (r < 86)
			send_word(MODE_ADD, 7'($urandom), 7'($urandom));
		else if (r < 94)
			send_word(MODE_RUN, 7'($urandom), 7'($urandom));
		else if (r < 97)
			send_word(MODE_CLEAR, 7'($urandom), 7'($urandom));
		else
			send_word(MODE_NOP, 7'($urandom), 7'($urandom));
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (80) @(negedge clk);

		// directed: run at reset size, edge extremes, self loop, repeats, clear, nop
		send_word(MODE_RUN, 7'd0, 7'd0);
		send_word(MODE_ADD, 7'd1, 7'd64);
		send_word(MODE_ADD, 7'd64, 7'd1);
		send_word(MODE_ADD, 7'd0, 7'd5);
		send_word(MODE_ADD, 7'd5, 7'd65);
		send_word(MODE_ADD, 7'd127, 7'd127);
		send_word(MODE_ADD, 7'd2, 7'd2);
		send_word(MODE_ADD, 7'd1, 7'd3);
		send_word(MODE_ADD, 7'd1, 7'd3);
		send_word(MODE_ADD, 7'd3, 7'd2);
		send_word(MODE_NOP, 7'd1, 7'd2);
		drain_and_settle();
		write_vertex_count(7'd3);
		send_word(MODE_RUN, 7'd0, 7'd0);
		drain_and_settle();
		write_vertex_count(7'd64);
		send_word(MODE_RUN, 7'd0, 7'd0);
		drain_and_settle();
		write_vertex_count(7'd0);
		send_word(MODE_RUN, 7'd0, 7'd0);
		drain_and_settle();
		write_vertex_count(7'd127);
		send_word(MODE_RUN, 7'd0, 7'd0);
		send_word(MODE_CLEAR, 7'd0, 7'd0);
		send_word(MODE_RUN, 7'd0, 7'd0);
		drain_and_settle();

		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 27 : 64) : 0;
			recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 27 : 64) : 0;
			write_vertex_count(7'((phase == 0) ? 64 : $urandom_range(1, 12)));
			// long receiver hold-off over a full-size run while words keep coming
			if (phase == 0) begin
				hold_req++;
				send_word(MODE_RUN, 7'd0, 7'd0);
			end
			for (int k = 0; k < 60; k++)
				random_word();
			send_word(MODE_RUN, 7'd0, 7'd0);
			drain_and_settle();
		end

		drain_and_settle();
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
